>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files. Each use expects aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define OCC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OCC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/occ_pkg.sv
// ============================================================================
// occ_pkg
// Shared types and constants of the online consensus clustering block.
// ============================================================================
package occ_pkg;

    localparam int MAX_GROUPS_DEF  = 32;
    localparam int MAX_COLUMNS_DEF = 128;
    localparam int COUNT_BITS_DEF  = 16;

    // Widest group index and row length over the supported parameter range
    localparam int GRP_W = 8;
    localparam int LEN_W = 11;

    localparam int CMD_DEPTH = 2;

    localparam logic [2:0] CELL_MISSING = 3'd0;
    localparam logic [2:0] CELL_OTHER   = 3'd4;

    localparam logic [7:0] NCOLS_RESET = 8'd128;

    typedef enum logic [1:0] {
        CFG_CUTOFF  = 2'd0,
        CFG_OVERLAP = 2'd1,
        CFG_NCOLS   = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_JOIN  = 2'd0,
        CMD_FOUND = 2'd1,
        CMD_FULL  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [GRP_W-1:0] group;
        logic [LEN_W-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic idle;
    } back_stat_t;

    typedef enum logic [1:0] {
        F_FETCH,
        F_CELL,
        F_SEL,
        F_DECIDE
    } f_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CNT,
        B_RD,
        B_WR,
        B_DONE
    } b_state_t;

endpackage

>>> hw/rtl/occ_cmd_fifo.sv
// ============================================================================
// occ_cmd_fifo
// Short command queue between the row classifier and the group updater.
// ============================================================================
`include "assert_macros.svh"

module occ_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  occ_pkg::cmd_t push_cmd,
    input  logic          pop,
    output occ_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);

    localparam int DEPTH = occ_pkg::CMD_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    occ_pkg::cmd_t q_mem [DEPTH];

    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;

    assign full  = (count_reg == CNTW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    `OCC_ASSERT_IMP(a_no_overflow, push, (!full || pop), "command pushed into full queue")
    `OCC_ASSERT_IMP(a_no_underflow, pop, !empty, "command popped from empty queue")

endmodule

>>> hw/rtl/occ_front.sv
// ============================================================================
// occ_front
// Row classifier: tallies each cell against every consensus in use, then picks a group or drops the row.
// ============================================================================
`include "assert_macros.svh"

module occ_front #(
    parameter int MAX_GROUPS  = occ_pkg::MAX_GROUPS_DEF,
    parameter int MAX_COLUMNS = occ_pkg::MAX_COLUMNS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,
    input  logic [16:0]                        similarity_cutoff,
    input  logic [7:0]                         min_overlap,
    input  logic [7:0]                         num_columns,
    output logic                               cons_rd_en,
    output logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] cons_rd_addr,
    input  logic [MAX_GROUPS*3-1:0]            cons_rd_data,
    output logic                               rc_we,
    output logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] rc_addr,
    output logic [2:0]                         rc_data,
    output logic                               push,
    output occ_pkg::cmd_t                      push_cmd,
    input  logic                               fifo_full,
    input  logic                               fifo_empty,
    input  occ_pkg::back_stat_t                back_stat
);

    localparam int GW = $clog2(MAX_GROUPS);
    localparam int UW = $clog2(MAX_GROUPS + 1);
    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int TW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS + 1) : 1;
    localparam int NW = (TW > 8) ? TW : 8;

    occ_pkg::f_state_t state_reg, state_next;

    logic [CW-1:0] pos_reg, pos_next;
    logic [TW-1:0] rowlen_reg, rowlen_next;
    logic [UW-1:0] used_reg, used_next;
    logic [UW-1:0] sel_reg, sel_next;
    logic          have_reg, have_next;
    logic [GW-1:0] best_reg, best_next;
    logic [TW-1:0] be_reg, be_next;
    logic [TW-1:0] bc_reg, bc_next;

    logic [TW-1:0] common_reg [MAX_GROUPS];
    logic [TW-1:0] common_next [MAX_GROUPS];
    logic [TW-1:0] equal_reg [MAX_GROUPS];
    logic [TW-1:0] equal_next [MAX_GROUPS];

    logic [2:0]      code;
    logic [2:0]      lead;
    logic [NW-1:0]   ncols_ext;
    logic [TW-1:0]   len_eff;
    logic [TW-1:0]   pos_p1;
    logic [TW-1:0]   c_sel, e_sel, cd, ed;
    logic [2*TW-1:0] prod_new, prod_best;
    logic [TW+16:0]  lhs, rhs;
    logic            accept;

    assign accept = s_tvalid && s_tready;

    always_comb begin
        ncols_ext = NW'(num_columns);
        if (ncols_ext == '0) begin
            len_eff = TW'(1);
        end else if (ncols_ext > NW'(MAX_COLUMNS)) begin
            len_eff = TW'(MAX_COLUMNS);
        end else begin
            len_eff = TW'(ncols_ext);
        end
    end

    assign pos_p1 = TW'(pos_reg) + 1'b1;
    assign code   = (s_tdata[2:0] > occ_pkg::CELL_OTHER) ? occ_pkg::CELL_OTHER : s_tdata[2:0];

    always_comb begin
        c_sel     = common_reg[sel_reg[GW-1:0]];
        e_sel     = equal_reg[sel_reg[GW-1:0]];
        cd        = (c_sel == '0) ? TW'(1) : c_sel;
        ed        = (c_sel == '0) ? '0 : e_sel;
        prod_new  = (2*TW)'(ed) * (2*TW)'(bc_reg);
        prod_best = (2*TW)'(be_reg) * (2*TW)'(cd);
        lhs       = (TW+17)'({be_reg, 16'h0000});
        rhs       = (TW+17)'(similarity_cutoff) * (TW+17)'(bc_reg);
    end

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        rowlen_next  = rowlen_reg;
        used_next    = used_reg;
        sel_next     = sel_reg;
        have_next    = have_reg;
        best_next    = best_reg;
        be_next      = be_reg;
        bc_next      = bc_reg;
        s_tready     = 1'b0;
        cons_rd_en   = 1'b0;
        cons_rd_addr = pos_reg;
        rc_we        = 1'b0;
        rc_addr      = pos_reg;
        rc_data      = code;
        push         = 1'b0;
        push_cmd     = '{kind: occ_pkg::CMD_FULL, group: '0, len: '0};
        lead         = '0;
        for (int g = 0; g < MAX_GROUPS; g++) begin
            common_next[g] = common_reg[g];
            equal_next[g]  = equal_reg[g];
        end

        unique case (state_reg)
            occ_pkg::F_FETCH: begin
                cons_rd_en = 1'b1;
                if (fifo_empty && back_stat.idle) begin
                    state_next = occ_pkg::F_CELL;
                end
            end
            occ_pkg::F_CELL: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    rc_we = 1'b1;
                    for (int g = 0; g < MAX_GROUPS; g++) begin
                        lead = cons_rd_data[g*3 +: 3];
                        if (UW'(g) < used_reg && code != occ_pkg::CELL_MISSING
                            && lead != occ_pkg::CELL_MISSING) begin
                            common_next[g] = common_reg[g] + 1'b1;
                            if ((code == 3'd2 || code == 3'd3) == (lead == 3'd2 || lead == 3'd3)) begin
                                equal_next[g] = equal_reg[g] + 1'b1;
                            end
                        end
                    end
                    if (pos_p1 >= len_eff) begin
                        pos_next    = '0;
                        rowlen_next = pos_p1;
                        sel_next    = '0;
                        have_next   = 1'b0;
                        best_next   = '0;
                        be_next     = '0;
                        bc_next     = TW'(1);
                        state_next  = occ_pkg::F_SEL;
                    end else begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = occ_pkg::F_FETCH;
                    end
                end
            end
            occ_pkg::F_SEL: begin
                if (sel_reg < used_reg) begin
                    if (NW'(c_sel) >= NW'(min_overlap) && (!have_reg || prod_new > prod_best)) begin
                        have_next = 1'b1;
                        best_next = sel_reg[GW-1:0];
                        be_next   = ed;
                        bc_next   = cd;
                    end
                    sel_next = sel_reg + 1'b1;
                end else begin
                    state_next = occ_pkg::F_DECIDE;
                end
            end
            occ_pkg::F_DECIDE: begin
                if (!fifo_full) begin
                    push = 1'b1;
                    push_cmd.len = occ_pkg::LEN_W'(rowlen_reg);
                    if (have_reg && lhs >= rhs) begin
                        push_cmd.kind  = occ_pkg::CMD_JOIN;
                        push_cmd.group = occ_pkg::GRP_W'(best_reg);
                    end else if (used_reg >= UW'(MAX_GROUPS)) begin
                        push_cmd.kind = occ_pkg::CMD_FULL;
                    end else begin
                        push_cmd.kind  = occ_pkg::CMD_FOUND;
                        push_cmd.group = occ_pkg::GRP_W'(used_reg);
                        used_next      = used_reg + 1'b1;
                    end
                    for (int g = 0; g < MAX_GROUPS; g++) begin
                        common_next[g] = '0;
                        equal_next[g]  = '0;
                    end
                    state_next = occ_pkg::F_FETCH;
                end
            end
            default: state_next = occ_pkg::F_FETCH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= occ_pkg::F_FETCH;
            pos_reg   <= '0;
            used_reg  <= '0;
            sel_reg   <= '0;
            have_reg  <= 1'b0;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                common_reg[g] <= '0;
                equal_reg[g]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            used_reg  <= used_next;
            sel_reg   <= sel_next;
            have_reg  <= have_next;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                common_reg[g] <= common_next[g];
                equal_reg[g]  <= equal_next[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        rowlen_reg <= rowlen_next;
        best_reg   <= best_next;
        be_reg     <= be_next;
        bc_reg     <= bc_next;
    end

    `OCC_ASSERT_IMP(a_cell_back_idle, s_tready, (fifo_empty && back_stat.idle),
        "cell taken while consensus update in flight")
    `OCC_ASSERT_NXT(a_tally_cleared, push, (common_reg[0] == '0 && equal_reg[0] == '0),
        "tallies not cleared after row decision")

endmodule

>>> hw/rtl/occ_back.sv
// ============================================================================
// occ_back
// Group updater: applies join and found commands to counts and consensus, and emits one result per command.
// ============================================================================
`include "assert_macros.svh"

module occ_back #(
    parameter int MAX_GROUPS  = occ_pkg::MAX_GROUPS_DEF,
    parameter int MAX_COLUMNS = occ_pkg::MAX_COLUMNS_DEF,
    parameter int COUNT_BITS  = occ_pkg::COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  occ_pkg::cmd_t                      head,
    input  logic                               fifo_empty,
    output logic                               pop,
    input  logic                               rc_we,
    input  logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] rc_addr,
    input  logic [2:0]                         rc_data,
    input  logic                               cons_rd_en,
    input  logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] cons_rd_addr,
    output logic [MAX_GROUPS*3-1:0]            cons_rd_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,
    output logic [1:0]                         m_tuser,
    output occ_pkg::back_stat_t                back_stat
);

    localparam int GW = $clog2(MAX_GROUPS);
    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int TW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS + 1) : 1;
    localparam int CB = COUNT_BITS;

    logic [2:0]          rc_mem   [MAX_COLUMNS];
    logic [MAX_GROUPS*3-1:0] cons_mem [MAX_COLUMNS];
    logic [4*CB-1:0]     cls_mem  [MAX_GROUPS][MAX_COLUMNS];
    logic [CB-1:0]       mcnt_mem [MAX_GROUPS];

    logic [2:0]              rc_q;
    logic [MAX_GROUPS*3-1:0] cons_q;
    logic [4*CB-1:0]         cls_q;
    logic [CB-1:0]           mc_q;

    occ_pkg::b_state_t  state_reg, state_next;
    occ_pkg::cmd_kind_t kind_reg, kind_next;
    logic [GW-1:0] grp_reg, grp_next;
    logic [TW-1:0] len_reg, len_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CB-1:0] n_reg, n_next;

    logic        out_valid_reg, out_valid_next;
    logic [4:0]  idx_reg, idx_next;
    logic        fresh_reg, fresh_next;
    logic [15:0] size_reg, size_next;
    logic        full_reg, full_next;

    logic          b_rd, mc_rd, mc_we, cls_we, cons_we;
    logic [CB-1:0] mc_wdata;
    logic [GW-1:0] mc_raddr;
    logic [4*CB-1:0]         cls_wdata;
    logic [MAX_GROUPS*3-1:0] cons_wdata;

    logic [2:0]      v;
    logic [1:0]      k;
    logic [CB-1:0]   cnt [4];
    logic [CB-1:0]   present;
    logic [CB+4:0]   p20;
    logic [2:0]      new_code;
    logic [15:0]     size_sat;

    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = {3'b000, size_reg, idx_reg};
    assign m_tuser        = {full_reg, fresh_reg};
    assign back_stat.idle = (state_reg == occ_pkg::B_IDLE);

    assign size_sat = (|(n_reg >> 16)) ? 16'hFFFF : 16'(n_reg);

    // Column update datapath
    always_comb begin
        v = (TW'(col_reg) < len_reg) ? rc_q : occ_pkg::CELL_MISSING;
        k = (v >= 3'd1 && v <= 3'd3) ? v[1:0] : 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (kind_reg == occ_pkg::CMD_JOIN) begin
                cnt[i] = cls_q[i*CB +: CB];
                if (k == 2'(i) && cnt[i] != '1) begin
                    cnt[i] = cnt[i] + 1'b1;
                end
            end else begin
                cnt[i] = (k == 2'(i)) ? CB'(1) : '0;
            end
        end
        present = (n_reg > cnt[0]) ? n_reg - cnt[0] : '0;
        p20     = ((CB+5)'(present) << 4) + ((CB+5)'(present) << 2);
        if (kind_reg != occ_pkg::CMD_JOIN) begin
            new_code = v;
        end else if (p20 < (CB+5)'(n_reg)) begin
            new_code = occ_pkg::CELL_MISSING;
        end else if (cnt[1] >= cnt[2]) begin
            new_code = (cnt[1] >= cnt[3]) ? 3'd1 : 3'd3;
        end else begin
            new_code = (cnt[2] >= cnt[3]) ? 3'd2 : 3'd3;
        end
        cls_wdata = {cnt[3], cnt[2], cnt[1], cnt[0]};
        for (int g = 0; g < MAX_GROUPS; g++) begin
            cons_wdata[g*3 +: 3] = (grp_reg == GW'(g)) ? new_code : cons_q[g*3 +: 3];
        end
    end

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        grp_next       = grp_reg;
        len_next       = len_reg;
        col_next       = col_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg && !m_tready;
        idx_next       = idx_reg;
        fresh_next     = fresh_reg;
        size_next      = size_reg;
        full_next      = full_reg;
        pop            = 1'b0;
        b_rd           = 1'b0;
        mc_rd          = 1'b0;
        mc_raddr       = GW'(head.group);
        mc_we          = 1'b0;
        mc_wdata       = (kind_reg == occ_pkg::CMD_JOIN && mc_q != '1) ? mc_q + 1'b1 :
                         (kind_reg == occ_pkg::CMD_JOIN) ? mc_q : CB'(1);
        cls_we         = 1'b0;
        cons_we        = 1'b0;

        unique case (state_reg)
            occ_pkg::B_IDLE: begin
                if (!fifo_empty) begin
                    pop       = 1'b1;
                    mc_rd     = 1'b1;
                    kind_next = head.kind;
                    grp_next  = GW'(head.group);
                    len_next  = TW'(head.len);
                    col_next  = '0;
                    state_next = (head.kind == occ_pkg::CMD_FULL) ? occ_pkg::B_DONE
                                                                  : occ_pkg::B_CNT;
                end
            end
            occ_pkg::B_CNT: begin
                mc_we      = 1'b1;
                n_next     = mc_wdata;
                state_next = occ_pkg::B_RD;
            end
            occ_pkg::B_RD: begin
                b_rd       = 1'b1;
                state_next = occ_pkg::B_WR;
            end
            occ_pkg::B_WR: begin
                cls_we  = 1'b1;
                cons_we = 1'b1;
                if (col_reg == CW'(MAX_COLUMNS - 1)) begin
                    state_next = occ_pkg::B_DONE;
                end else begin
                    col_next   = col_reg + 1'b1;
                    state_next = occ_pkg::B_RD;
                end
            end
            occ_pkg::B_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    if (kind_reg == occ_pkg::CMD_FULL) begin
                        idx_next   = '0;
                        fresh_next = 1'b0;
                        size_next  = '0;
                        full_next  = 1'b1;
                    end else begin
                        idx_next   = 5'(grp_reg);
                        fresh_next = (kind_reg == occ_pkg::CMD_FOUND);
                        size_next  = size_sat;
                        full_next  = 1'b0;
                    end
                    state_next = occ_pkg::B_IDLE;
                end
            end
            default: state_next = occ_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= occ_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        grp_reg   <= grp_next;
        len_reg   <= len_next;
        col_reg   <= col_next;
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        fresh_reg <= fresh_next;
        size_reg  <= size_next;
        full_reg  <= full_next;
    end

    always_ff @(posedge aclk) begin
        if (rc_we) begin
            rc_mem[rc_addr] <= rc_data;
        end
        if (b_rd) begin
            rc_q <= rc_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cons_rd_en) begin
            cons_rd_data <= cons_mem[cons_rd_addr];
        end
        if (b_rd) begin
            cons_q <= cons_mem[col_reg];
        end
        if (cons_we) begin
            cons_mem[col_reg] <= cons_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_rd) begin
            cls_q <= cls_mem[grp_reg][col_reg];
        end
        if (cls_we) begin
            cls_mem[grp_reg][col_reg] <= cls_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mc_rd) begin
            mc_q <= mcnt_mem[mc_raddr];
        end
        if (mc_we) begin
            mcnt_mem[grp_reg] <= mc_wdata;
        end
    end

    `OCC_ASSERT_IMP(a_full_result, (out_valid_reg && full_reg),
        (size_reg == '0 && idx_reg == '0 && !fresh_reg), "dropped row carries group data")

endmodule

>>> hw/rtl/online_consensus_clustering.sv
// ============================================================================
// online_consensus_clustering
// Streams strand-state rows in and assigns each finished row to a group, or drops it when the table is full.
// ============================================================================
// For each cell, F_FETCH reads the consensus row for its column and F_CELL
// then tallies the cell against all groups in use at once. After the last
// cell of a row, the best group is searched one group per cycle, then the
// join or found update reads and writes back each of all MAX_COLUMNS columns
// in turn (B_RD, then B_WR); the next row's first cell waits for that update
// to finish. One result per row appears on the m_ side; it waits in an output
// register while the next row streams in. No clearing pass follows reset.

module online_consensus_clustering #(
    parameter int MAX_GROUPS  = occ_pkg::MAX_GROUPS_DEF,
    parameter int MAX_COLUMNS = occ_pkg::MAX_COLUMNS_DEF,
    parameter int COUNT_BITS  = occ_pkg::COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [2:0] cell_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [4:0] group_index, [20:5] group_size
    output logic [1:0]  m_tuser,    // [0] new_group, [1] table_full
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic [16:0] cutoff_reg, cutoff_next;
    logic [7:0]  overlap_reg, overlap_next;
    logic [7:0]  ncols_reg, ncols_next;

    logic                    cons_rd_en;
    logic [CW-1:0]           cons_rd_addr;
    logic [MAX_GROUPS*3-1:0] cons_rd_data;
    logic                    rc_we;
    logic [CW-1:0]           rc_addr;
    logic [2:0]              rc_data;
    logic                    push, pop, fifo_full, fifo_empty;
    occ_pkg::cmd_t           push_cmd, head;
    occ_pkg::back_stat_t     back_stat;

    assign cfg_ready = 1'b1;

    always_comb begin
        cutoff_next  = cutoff_reg;
        overlap_next = overlap_reg;
        ncols_next   = ncols_reg;
        if (cfg_valid) begin
            unique case (occ_pkg::cfg_reg_t'(cfg_index))
                occ_pkg::CFG_CUTOFF:  cutoff_next  = cfg_data;
                occ_pkg::CFG_OVERLAP: overlap_next = cfg_data[7:0];
                occ_pkg::CFG_NCOLS:   ncols_next   = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg  <= '0;
            overlap_reg <= '0;
            ncols_reg   <= occ_pkg::NCOLS_RESET;
        end else begin
            cutoff_reg  <= cutoff_next;
            overlap_reg <= overlap_next;
            ncols_reg   <= ncols_next;
        end
    end

    occ_front #(
        .MAX_GROUPS  (MAX_GROUPS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .similarity_cutoff (cutoff_reg),
        .min_overlap       (overlap_reg),
        .num_columns       (ncols_reg),
        .cons_rd_en        (cons_rd_en),
        .cons_rd_addr      (cons_rd_addr),
        .cons_rd_data      (cons_rd_data),
        .rc_we             (rc_we),
        .rc_addr           (rc_addr),
        .rc_data           (rc_data),
        .push              (push),
        .push_cmd          (push_cmd),
        .fifo_full         (fifo_full),
        .fifo_empty        (fifo_empty),
        .back_stat         (back_stat)
    );

    occ_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    occ_back #(
        .MAX_GROUPS  (MAX_GROUPS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .fifo_empty   (fifo_empty),
        .pop          (pop),
        .rc_we        (rc_we),
        .rc_addr      (rc_addr),
        .rc_data      (rc_data),
        .cons_rd_en   (cons_rd_en),
        .cons_rd_addr (cons_rd_addr),
        .cons_rd_data (cons_rd_data),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .back_stat    (back_stat)
    );

endmodule

>>> test/tb_online_consensus_clustering.sv
// ----------------------------------------------------------------------------
// tb_online_consensus_clustering
// Streams strand-state rows into the clustering block and checks each row's
// group assignment against a behavioral predictor kept in the testbench.
// ----------------------------------------------------------------------------
module tb_online_consensus_clustering;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NG = 32;
    localparam int NC = 128;
    localparam int CMAX = 65535;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;

    online_consensus_clustering uut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    typedef struct packed {
        logic [4:0]  grp;
        logic        fresh;
        logic [15:0] size;
        logic        full;
    } assign_t;

    // predictor state
    int unsigned cutoff, overlap, ncols;
    logic [2:0]  row_buf [NC];
    int unsigned col_pos, used;
    logic [2:0]  cons [NG][NC];
    int unsigned cls [NG][NC][4];
    int unsigned members [NG];
    int unsigned common_cnt [NG], equal_cnt [NG];

    assign_t     pending_assign [$];
    int          errors = 0;
    bit          quiet = 1'b0;   // receiver stall-free stretch
    bit          burst = 1'b0;   // sender gap-free stretch
    int          rcv_count = 0;

    function automatic int unsigned sat(int unsigned v);
        return v < CMAX ? v + 1 : v;
    endfunction

    function automatic bit upper(logic [2:0] v);
        return v == 3'd2 || v == 3'd3;
    endfunction

    function automatic int unsigned klass(logic [2:0] v);
        return (v >= 3'd1 && v <= 3'd3) ? v : 0;
    endfunction

    task automatic update_group(int unsigned g, int unsigned len, bit found);
        int unsigned n, pres, k;
        logic [2:0] v;
        if (found) members[g] = 1;
        else members[g] = sat(members[g]);
        n = members[g];
        for (int c = 0; c < NC; c++) begin
            v = c < len ? row_buf[c] : occ_pkg::CELL_MISSING;
            k = klass(v);
            if (found) begin
                for (int j = 0; j < 4; j++) cls[g][c][j] = 0;
                cls[g][c][k] = 1;
                cons[g][c] = v;
            end else begin
                cls[g][c][k] = sat(cls[g][c][k]);
                pres = n > cls[g][c][0] ? n - cls[g][c][0] : 0;
                if (pres * 20 < n) cons[g][c] = 3'd0;
                else if (cls[g][c][1] >= cls[g][c][2])
                    cons[g][c] = cls[g][c][1] >= cls[g][c][3] ? 3'd1 : 3'd3;
                else
                    cons[g][c] = cls[g][c][2] >= cls[g][c][3] ? 3'd2 : 3'd3;
            end
        end
    endtask

    task automatic predict_cell(logic [2:0] raw);
        logic [2:0] code;
        int unsigned pos, lim, best, c;
        longint unsigned be, bc, cd, ed;
        bit have;
        assign_t r;
        code = raw > 3'd4 ? occ_pkg::CELL_OTHER : raw;
        pos = col_pos >= NC ? NC - 1 : col_pos;
        row_buf[pos] = code;
        for (int g = 0; g < used; g++)
            if (code != 0 && cons[g][pos] != 0) begin
                common_cnt[g]++;
                if (upper(code) == upper(cons[g][pos])) equal_cnt[g]++;
            end
        pos++;
        lim = ncols < 1 ? 1 : (ncols > NC ? NC : ncols);
        if (pos < lim) begin
            col_pos = pos;
            return;
        end
        col_pos = 0;
        have = 0; best = 0; be = 0; bc = 1;
        for (int g = 0; g < used; g++) begin
            c = common_cnt[g];
            if (c < overlap) continue;
            cd = c ? c : 1;
            ed = c ? equal_cnt[g] : 0;
            if (!have || ed * bc > be * cd) begin
                have = 1; best = g; be = ed; bc = cd;
            end
        end
        r = '0;
        if (have && be * 65536 >= longint'(cutoff) * bc) begin
            update_group(best, pos, 0);
            r.grp = 5'(best);
            r.size = 16'(members[best]);
        end else if (used >= NG) begin
            r.full = 1'b1;
        end else begin
            update_group(used, pos, 1);
            r.grp = 5'(used);
            r.fresh = 1'b1;
            r.size = 16'd1;
            used++;
        end
        for (int g = 0; g < NG; g++) begin
            common_cnt[g] = 0;
            equal_cnt[g] = 0;
        end
        pending_assign = {pending_assign, r};
    endtask

    task automatic send_cell(logic [2:0] code);
        while (!burst && $urandom_range(99) < 10) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_cell(code);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending_assign.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(occ_pkg::cfg_reg_t idx, int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 17'(val);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            occ_pkg::CFG_CUTOFF:  cutoff = val & 17'h1FFFF;
            occ_pkg::CFG_OVERLAP: overlap = val & 8'hFF;
            default:              ncols = val & 8'hFF;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_row(int unsigned len, int unsigned mode);
        for (int i = 0; i < len; i++)
            case (mode)
                0: send_cell(3'($urandom_range(7)));
                1: send_cell(3'd2);
                2: send_cell(occ_pkg::CELL_MISSING);
                default: send_cell(3'($urandom_range(4)));
            endcase
    endtask

    // noisy variant of a base row keeps joins frequent
    task automatic send_variant(logic [2:0] base [NC], int unsigned len);
        for (int i = 0; i < len; i++)
            send_cell($urandom_range(99) < 12 ? 3'($urandom_range(7)) : base[i]);
    endtask

    task automatic test_directed();
        write_reg(occ_pkg::CFG_NCOLS, 4);
        send_row(4, 1);          // founder, all upper side
        send_row(4, 1);          // joins at cutoff 0
        send_row(4, 2);          // all missing
        send_cell(3'd7); send_cell(3'd5); send_cell(3'd1); send_cell(3'd4);
        drain();
        write_reg(occ_pkg::CFG_CUTOFF, 65536);
        write_reg(occ_pkg::CFG_OVERLAP, 4);
        send_row(4, 1);
        send_row(4, 0);
        drain();
        write_reg(occ_pkg::CFG_CUTOFF, 65537 + 100);  // above one: always found
        write_reg(occ_pkg::CFG_OVERLAP, 255);
        send_row(4, 3);
        drain();
        write_reg(occ_pkg::CFG_NCOLS, 0);             // treated as one column
        send_row(2, 0);
        drain();
    endtask

    task automatic test_full_table();
        write_reg(occ_pkg::CFG_NCOLS, 2);
        write_reg(occ_pkg::CFG_CUTOFF, 65536);
        write_reg(occ_pkg::CFG_OVERLAP, 3);           // never qualifies
        while (used < NG) send_row(2, 0);
        send_row(2, 0);
        send_row(2, 3);
        drain();
    endtask

    task automatic test_random(int unsigned items);
        int unsigned sent, len;
        logic [2:0] base [NC];
        sent = 0;
        while (sent < items) begin
            drain();
            len = $urandom_range(99) < 5 ? ($urandom_range(1) ? 128 : 200) :
                  $urandom_range(1, 12);
            write_reg(occ_pkg::CFG_NCOLS, len);
            write_reg(occ_pkg::CFG_CUTOFF,
                      $urandom_range(3) == 0 ? 0 : $urandom_range(65536));
            write_reg(occ_pkg::CFG_OVERLAP,
                      $urandom_range(3) == 0 ? 0 : $urandom_range(len));
            if (len > NC) len = NC;
            for (int i = 0; i < NC; i++) base[i] = 3'($urandom_range(4));
            burst = $urandom_range(4) == 0;
            for (int r = 0; r < 6 && sent < items; r++) begin
                if ($urandom_range(4) == 0) send_row(len, 0);
                else send_variant(base, len);
                sent += len;
            end
            burst = 1'b0;
        end
        drain();
        // lower the row length mid-row
        write_reg(occ_pkg::CFG_NCOLS, 6);
        send_row(4, 0);
        write_reg(occ_pkg::CFG_NCOLS, 2);
        send_row(1, 0);
        drain();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || $urandom_range(99) >= 10;
            if (m_tvalid && m_tready) begin
                if (pending_assign.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected transfer %h/%b", m_tdata, m_tuser);
                end else begin
                    assign_t e;
                    e = pending_assign.pop_front();
                    if (m_tdata[4:0] !== e.grp || m_tdata[20:5] !== e.size ||
                        m_tdata[23:21] !== 3'd0 || m_tuser[0] !== e.fresh ||
                        m_tuser[1] !== e.full) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp grp %0d size %0d new %b full %b, got %0d %0d %b %b",
                                e.grp, e.size, e.fresh, e.full, m_tdata[4:0],
                                m_tdata[20:5], m_tuser[0], m_tuser[1]);
                    end
                end
                rcv_count++;
                quiet <= (rcv_count % 200) >= 150;
            end
        end
    end

    initial begin
        cutoff = 0; overlap = 0; ncols = 128; col_pos = 0; used = 0;
        for (int g = 0; g < NG; g++) begin
            common_cnt[g] = 0; equal_cnt[g] = 0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_table();
        // table stays full from here: rows either join or are dropped
        test_random(1400);
        drain();
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #60ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> online_consensus_clustering.f
+incdir+hw/rtl
hw/rtl/occ_pkg.sv
hw/rtl/occ_cmd_fifo.sv
hw/rtl/occ_front.sv
hw/rtl/occ_back.sv
hw/rtl/online_consensus_clustering.sv
test/tb_online_consensus_clustering.sv
